// ===== rtl/swm_pkg.sv =====
// Package for the sliding window minimum core.
// Holds shared widths, the controller state type and the command and status structs.
// No dependencies.
package swm_pkg;

    // Default deque depth (largest supported window).
    localparam int MAX_WINDOW = 64;

    // Fixed field widths.
    localparam int SAMPLE_W = 32;
    localparam int WSIZE_W  = 7;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic drop;
        logic pop;
        logic push;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop_req;
        logic pop_req;
        logic emit_req;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/swm_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Read returns the contents before a write at the same edge.
// No dependencies.
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== rtl/swm_ctrl.sv =====
// Controller state machine for the sliding window minimum core.
// Sequences accept, front drops, back pops and the push of each sample.
// Depends on swm_pkg.
module swm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  swm_pkg::t_status i_status,
    output swm_pkg::t_cmd    o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = swm_pkg::ST_SCAN;
                end
            end
            swm_pkg::ST_SCAN: begin
                if (!i_status.drop_req && !i_status.pop_req &&
                    (!i_status.emit_req || i_status.out_free)) begin
                    n_state = swm_pkg::ST_IDLE;
                end
            end
            default: n_state = swm_pkg::ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            swm_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            swm_pkg::ST_SCAN: begin
                // Drops at the front come first, then pops at the back, then the push.
                priority if (i_status.drop_req) begin
                    o_cmd.drop = 1'b1;
                end else if (i_status.pop_req) begin
                    o_cmd.pop = 1'b1;
                end else if (!i_status.emit_req || i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.emit = i_status.emit_req;
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== rtl/swm_dp.sv =====
// Datapath for the sliding window minimum core: deque pointers, counters,
// window size register, deque RAM and output register.
// Depends on swm_pkg and swm_ram.
module swm_dp #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                              i_start_req,
    input  logic                              i_cfg_valid,
    input  logic [swm_pkg::WSIZE_W-1:0]       i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_min,
    input  swm_pkg::t_cmd                      i_cmd,
    output swm_pkg::t_status                   o_status
);

    localparam int AW = $clog2(MAX_WINDOW);          // ring pointer width
    localparam int WW = $clog2(MAX_WINDOW + 1);      // count width
    localparam int PW = $clog2(2 * MAX_WINDOW);      // position width
    localparam int CW = (PW > swm_pkg::WSIZE_W) ? PW : swm_pkg::WSIZE_W;
    localparam int SW = swm_pkg::SAMPLE_W;
    localparam int EW = SW + PW;                     // deque entry width

    logic signed [SW-1:0] r_sample;
    logic [AW-1:0]        r_front, n_front;
    logic [AW-1:0]        r_back, n_back;
    logic [WW-1:0]        r_occ, n_occ;
    logic [PW-1:0]        r_pos, n_pos;
    logic [WW-1:0]        r_seen, n_seen;
    logic [swm_pkg::WSIZE_W-1:0] r_wsize;
    logic                 r_out_valid, n_out_valid;
    logic signed [SW-1:0] r_out_min;

    logic [EW-1:0]        front_entry, back_entry;
    logic signed [SW-1:0] front_val, back_val, result;
    logic [PW-1:0]        front_pos, pos_inc;
    logic [PW:0]          age_x;
    logic [PW-1:0]        age;
    logic [CW-1:0]        wsz_c, w_eff;
    logic [WW-1:0]        seen_inc;
    logic [AW-1:0]        front_inc, back_inc, back_dec, rd_back;
    logic                 out_free;

    // Ring pointer neighbors.
    assign front_inc = (r_front == AW'(MAX_WINDOW - 1)) ? '0 : r_front + 1'b1;
    assign back_inc  = (r_back == AW'(MAX_WINDOW - 1)) ? '0 : r_back + 1'b1;
    assign back_dec  = (r_back == '0) ? AW'(MAX_WINDOW - 1) : r_back - 1'b1;
    assign rd_back   = (n_back == '0) ? AW'(MAX_WINDOW - 1) : n_back - 1'b1;

    // Effective window: zero counts as one, large sizes saturate.
    assign wsz_c = CW'(r_wsize);
    always_comb begin
        priority if (wsz_c == '0) begin
            w_eff = CW'(1);
        end else if (wsz_c > CW'(MAX_WINDOW)) begin
            w_eff = CW'(MAX_WINDOW);
        end else begin
            w_eff = wsz_c;
        end
    end

    // Entry fields from the RAM read ports.
    assign front_val = front_entry[EW-1:PW];
    assign front_pos = front_entry[PW-1:0];
    assign back_val  = back_entry[EW-1:PW];

    // Age of the front entry, modulo twice the depth.
    assign age_x = (r_pos >= front_pos)
                 ? {1'b0, r_pos} - {1'b0, front_pos}
                 : {1'b0, r_pos} + (PW+1)'(2 * MAX_WINDOW) - {1'b0, front_pos};
    assign age   = age_x[PW-1:0];

    assign pos_inc  = (r_pos == PW'(2 * MAX_WINDOW - 1)) ? '0 : r_pos + 1'b1;
    assign seen_inc = (r_seen == WW'(MAX_WINDOW)) ? r_seen : r_seen + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    // With an empty deque the pushed sample is the minimum.
    assign result = (r_occ == '0) ? r_sample : front_val;

    // Status toward the controller.
    always_comb begin
        o_status.drop_req = (r_occ != '0) && (CW'(age) >= w_eff);
        o_status.pop_req  = (r_occ != '0) && (back_val > r_sample);
        o_status.emit_req = (CW'(seen_inc) >= w_eff);
        o_status.out_free = out_free;
    end

    // Next values of pointers and counters.
    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_occ   = r_occ;
        n_pos   = r_pos;
        n_seen  = r_seen;
        priority if (i_cmd.accept) begin
            if (i_start_req) begin
                n_front = '0;
                n_back  = '0;
                n_occ   = '0;
                n_pos   = '0;
                n_seen  = '0;
            end
        end else if (i_cmd.drop) begin
            n_front = front_inc;
            n_occ   = r_occ - 1'b1;
        end else if (i_cmd.pop) begin
            n_back = back_dec;
            n_occ  = r_occ - 1'b1;
        end else if (i_cmd.push) begin
            n_back = back_inc;
            n_occ  = r_occ + 1'b1;
            n_pos  = pos_inc;
            n_seen = seen_inc;
        end
    end

    // Output register: loaded on emit, cleared once the transfer completes.
    always_comb begin
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_occ       <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_wsize     <= swm_pkg::WSIZE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_front     <= n_front;
            r_back      <= n_back;
            r_occ       <= n_occ;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_wsize <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.emit) begin
            r_out_min <= result;
        end
    end

    // Deque storage; read addresses follow the next pointer values so the
    // registered read data lines up with the pointer registers.
    swm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.push),
        .i_waddr   (r_back),
        .i_wdata   ({r_sample, r_pos}),
        .i_raddr_a (n_front),
        .i_raddr_b (rd_back),
        .o_rdata_a (front_entry),
        .o_rdata_b (back_entry)
    );

    assign o_out_valid  = r_out_valid;
    assign o_window_min = r_out_min;

endmodule

// ===== rtl/sliding_window_minimum_core.sv =====
// Top level of the sliding window minimum core (monotonic deque).
// Depends on swm_pkg, swm_ctrl and swm_dp.
//
//  channel   handshake                  payload
//  input     i_in_valid / o_in_stall    i_sample, i_start_req
//  output    o_out_valid / i_out_stall  o_window_min
//  config    i_cfg_valid / o_cfg_ready  i_cfg_data (window size)
//
// An item passes through an accept step, one drop step for each front entry
// dropped (D) and one pop step for each back entry popped (P), and a push step.
// Each sample is pushed once and removed at most once, with one removal per
// cycle; a new sample is taken only after the last one has been pushed.
// Reset is synchronous and active low; no clearing pass follows it.
// A result waiting in the output register holds the push when the next
// result is due; the input stays stalled until that push is done.
module sliding_window_minimum_core #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_start_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_min,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swm_pkg::WSIZE_W-1:0]         i_cfg_data
);

    swm_pkg::t_cmd    cmd;
    swm_pkg::t_status status;

    // Configuration is taken only while idle with no input offered.
    assign o_cfg_ready = !o_in_stall && !i_in_valid;

    // Sequencer.
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Deque datapath.
    swm_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample     (i_sample),
        .i_start_req  (i_start_req),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_window_min (o_window_min),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule

// ===== rtl/swm_chk.sv =====
// Port-level checker for the sliding window minimum core, with its bind.
// Depends on swm_pkg and sliding_window_minimum_core.
module swm_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [swm_pkg::SAMPLE_W-1:0] o_window_min,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready
);

    // A stalled result stays valid and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_window_min))
        else $error("stalled result changed or dropped");

    // The block is busy in the cycle after it takes a sample.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous sample still in work");

    // A new result only appears while a sample is being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a sample in work");

    // A configuration transfer only happens while the block is idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> !o_in_stall && !i_in_valid)
        else $error("configuration taken while a sample was in work");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_minimum_core swm_chk u_swm_chk (.*);

// ===== tb/sliding_window_minimum_core_tb.sv =====
// Self-checking testbench for sliding_window_minimum_core.
// Drives a directed table and random sample streams, predicts each window minimum
// with its own monotonic deque, and depends on swm_pkg and the core only.
`timescale 1ns / 100ps

module sliding_window_minimum_core_tb;

    localparam int SW          = swm_pkg::SAMPLE_W;
    localparam int WW          = swm_pkg::WSIZE_W;
    localparam int DEPTH       = swm_pkg::MAX_WINDOW;
    localparam int POS_SPAN    = 2 * DEPTH;
    localparam int NUM_PHASES  = 14;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 150;
    localparam int DRAIN_LIMIT = 20000;
    localparam int DIR_ROWS    = 29;

    localparam logic signed [SW-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [SW-1:0] S_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [0:0] {
        ROW_XFER,
        ROW_WSIZE
    } t_row_kind;

    typedef enum int {
        PAT_FULL,
        PAT_SMALL,
        PAT_UP,
        PAT_DOWN,
        PAT_EXTREME
    } t_pattern;

    typedef struct packed {
        t_row_kind             kind;
        logic [WW-1:0]         wsize;
        logic signed [SW-1:0]  sample;
        logic                  start;
        logic                  typed;
        logic signed [SW-1:0]  min_val;
    } t_dir_row;

    // Directed table. Rows with typed set carry the minimum read straight off the
    // window length of one; all other rows are checked against the deque tracker.
    t_dir_row dir_rows [DIR_ROWS] = '{
        // Window of one after reset: the result is the sample itself.
        '{ROW_XFER,  7'd0, S_MIN,    1'b0, 1'b1, S_MIN},
        '{ROW_XFER,  7'd0, S_MAX,    1'b0, 1'b1, S_MAX},
        '{ROW_XFER,  7'd0, 32'sd0,   1'b1, 1'b1, 32'sd0},
        '{ROW_XFER,  7'd0, -32'sd1,  1'b0, 1'b1, -32'sd1},
        // A window size of zero behaves as a window of one.
        '{ROW_WSIZE, 7'd0, 32'sd0,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, S_MAX,    1'b0, 1'b1, S_MAX},
        '{ROW_XFER,  7'd0, S_MIN,    1'b1, 1'b1, S_MIN},
        '{ROW_XFER,  7'd0, 32'sd5,   1'b0, 1'b1, 32'sd5},
        // Window of three with a fresh start, ties and an extreme.
        '{ROW_WSIZE, 7'd3, 32'sd0,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd10,  1'b1, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, -32'sd3,  1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd7,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd7,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd8,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, S_MIN,    1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd1,   1'b1, 1'b0, 32'sd0},
        // Window of five over a rising ramp keeps every sample of the window in the deque.
        '{ROW_WSIZE, 7'd5, 32'sd0,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd1,   1'b1, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd2,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd3,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd4,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd5,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd6,   1'b0, 1'b0, 32'sd0},
        // Shrinking the window mid-stream drops the stale front entries.
        '{ROW_WSIZE, 7'd2, 32'sd0,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd9,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd8,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, S_MAX,    1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, 32'sd7,   1'b0, 1'b0, 32'sd0},
        '{ROW_XFER,  7'd0, -32'sd2,  1'b1, 1'b0, 32'sd0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic signed [SW-1:0] i_sample    = '0;
    logic                 i_start_req = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [WW-1:0]        i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic signed [SW-1:0] o_window_min;
    logic                 o_cfg_ready;

    // Tracker state: a monotonic deque of values and positions.
    logic signed [SW-1:0] dq_val [DEPTH];
    int                   dq_pos [DEPTH];
    int                   head;
    int                   tail;
    int                   fill;
    int                   next_pos;
    int                   seen;
    logic [WW-1:0]        win_reg;

    logic signed [SW-1:0] min_expected [$];
    logic signed [SW-1:0] want;
    logic signed [SW-1:0] run_val;
    int                   fail_cnt      = 0;
    int                   stall_left    = 0;
    bit                   tx_calm       = 1'b0;
    bit                   rx_calm       = 1'b0;
    bit                   long_hold_req = 1'b0;

    sliding_window_minimum_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_start_req  (i_start_req),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_window_min (o_window_min),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the tracker by one sample; returns 1 when a minimum is due.
    function automatic logic track_min(input logic signed [SW-1:0] s, input logic st,
                                       output logic signed [SW-1:0] m);
        int w;
        int age;
        int last;
        w = int'(win_reg);
        if (w == 0) w = 1;
        if (w > DEPTH) w = DEPTH;
        if (st) begin
            head = 0;
            tail = 0;
            fill = 0;
            next_pos = 0;
            seen = 0;
        end
        // Entries at least a window old leave from the front.
        while (fill > 0) begin
            age = (next_pos + POS_SPAN - dq_pos[head]) % POS_SPAN;
            if (age < w) break;
            head = (head + 1) % DEPTH;
            fill--;
        end
        // Entries strictly greater than the new sample leave from the back.
        while (fill > 0) begin
            last = (tail + DEPTH - 1) % DEPTH;
            if (!(dq_val[last] > s)) break;
            tail = last;
            fill--;
        end
        dq_val[tail] = s;
        dq_pos[tail] = next_pos;
        tail = (tail + 1) % DEPTH;
        fill++;
        next_pos = (next_pos + 1) % POS_SPAN;
        if (seen < DEPTH) seen++;
        m = dq_val[head];
        return seen >= w;
    endfunction

    // Sender gap: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Next sample of a random stream; ramps keep a running value with small steps.
    function automatic logic signed [SW-1:0] next_sample(input t_pattern pat);
        case (pat)
            PAT_SMALL: return int'($urandom_range(0, 8)) - 4;
            PAT_UP: begin
                if ($urandom_range(0, 15) == 0) return $urandom;
                run_val = run_val + int'($urandom_range(0, 3));
                return run_val;
            end
            PAT_DOWN: begin
                if ($urandom_range(0, 15) == 0) return $urandom;
                run_val = run_val - int'($urandom_range(0, 3));
                return run_val;
            end
            PAT_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // One input transfer; records the expected minimum once it is accepted.
    task automatic send_sample(input logic signed [SW-1:0] s, input logic st,
                               input logic typed, input logic signed [SW-1:0] typed_min,
                               input int gap);
        logic signed [SW-1:0] m;
        logic                 has;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample    = s;
        i_start_req = st;
        i_in_valid  = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        has = track_min(s, st, m);
        if (typed) begin
            min_expected = {min_expected, typed_min};
        end else if (has) begin
            min_expected = {min_expected, m};
        end
        @(negedge i_clk);
    endtask

    // Window size write; only issued while the core is idle.
    task automatic set_window(input logic [WW-1:0] v);
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_reg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Wait for every outstanding minimum, then let a sample with no result finish.
    task automatic settle();
        int waited;
        waited = 0;
        i_in_valid = 1'b0;
        while (min_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (min_expected.size() != 0) begin
            $display("%0t: %0d expected minimums never arrived", $time, min_expected.size());
            fail_cnt++;
            min_expected.delete();
        end
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output checker: every result transfer against the oldest expected minimum.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (min_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_window_min);
                fail_cnt++;
            end else begin
                want = min_expected[0];
                min_expected.delete(0);
                if (o_window_min !== want) begin
                    $display("%0t: window_min mismatch, expected %0d, actual %0d",
                             $time, want, o_window_min);
                    fail_cnt++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin : receiver
        int r;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_out_stall = 1'b0;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else if (rx_calm) begin
                i_out_stall = 1'b0;
            end else begin
                r = $urandom_range(0, 31);
                if (r < 20) begin
                    i_out_stall = 1'b0;
                end else if (r < 30) begin
                    i_out_stall = 1'b1;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    i_out_stall = 1'b1;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Run limit, well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, final check.
    initial begin : main_seq
        int            k;
        int            ph;
        int            n;
        int            r;
        logic          st;
        logic [WW-1:0] wsz;
        t_pattern      pat;

        head = 0;
        tail = 0;
        fill = 0;
        next_pos = 0;
        seen = 0;
        win_reg = 7'd1;
        run_val = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table.
        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_rows[k].kind == ROW_WSIZE) begin
                settle();
                set_window(dir_rows[k].wsize);
            end else begin
                send_sample(dir_rows[k].sample, dir_rows[k].start, dir_rows[k].typed,
                            dir_rows[k].min_val, pick_gap());
            end
        end

        // Random phases, each with its own window size, stream shape and pacing.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            pat = t_pattern'($urandom_range(0, 4));
            n = 40;
            case (ph)
                0: begin
                    wsz = 7'd64;
                    pat = PAT_UP;
                    n = 90;
                end
                1: begin
                    wsz = 7'd127;
                    pat = PAT_DOWN;
                    n = 80;
                end
                2: wsz = 7'd1;
                3: begin
                    wsz = WW'($urandom_range(1, 4));
                    tx_calm = 1'b1;
                    rx_calm = 1'b0;
                end
                default: begin
                    r = $urandom_range(0, 9);
                    if (r < 6) wsz = WW'($urandom_range(1, 8));
                    else if (r < 8) wsz = WW'($urandom_range(9, 64));
                    else if (r == 8) wsz = 7'd0;
                    else wsz = WW'($urandom_range(65, 127));
                end
            endcase
            set_window(wsz);
            run_val = ($urandom_range(0, 3) == 0) ? $urandom
                                                 : int'($urandom_range(0, 2000)) - 1000;
            // The receiver holds off while the sender keeps pushing samples.
            if (ph == 3) long_hold_req = 1'b1;
            for (k = 0; k < n; k++) begin
                if (k == 0) st = (ph == 0) || ($urandom_range(0, 3) == 0);
                else st = ($urandom_range(0, 49) == 0);
                send_sample(next_sample(pat), st, 1'b0, '0, pick_gap());
            end
        end

        settle();
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sliding_window_minimum_core.f =====
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/swm_ctrl.sv
rtl/swm_dp.sv
rtl/sliding_window_minimum_core.sv
rtl/swm_chk.sv
tb/sliding_window_minimum_core_tb.sv
